@@ src/cfs_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package cfs_pkg;

  typedef enum logic [1:0] {
    ACT_ENQUEUE = 2'd0,
    ACT_DEQUEUE = 2'd1,
    ACT_DISPLAY = 2'd2,
    ACT_SEARCH  = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_FOUND    = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_t;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned POS_W  = 5;

  typedef struct packed {
    status_t                    status;
    logic signed [DATA_W-1:0]   data;
    logic        [POS_W-1:0]    position;
    logic                       last;
  } result_t;

endpackage
`default_nettype wire

@@ src/circular_fifo_with_search_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Channel  Dir  Signals                      Contents
// s_axis   in   s_tvalid s_tready s_tdata    one command word: action and value
//               s_tuser
// m_axis   out  m_tvalid m_tready m_tdata    result words, m_tlast on the final one
//               m_tuser m_tlast
// Enqueue, dequeue and any command on an empty queue: accepted, the result is
// built in S_RESP, then it sits in the output register; a new word is taken
// once that result has moved into the output register.
// Display and search walk the queue one entry per cycle through the single RAM
// read port and the shared key comparator; the walk holds while a result waits
// on a full output register. Reset leaves the queue empty; the RAM is not
// cleared.
module circular_fifo_with_search_unit #(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,   // value[31:0]
  input  wire logic [1:0]  s_tuser,   // action[1:0]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [39:0]      m_tdata,   // data[31:0], position[36:32], zero[39:37]
  output logic [2:0]       m_tuser,   // status[2:0]
  output logic             m_tlast    // last
);
  import cfs_pkg::*;

  localparam int unsigned IW = $clog2(DEPTH);

  logic                  res_valid;
  logic                  res_ready;
  result_t               res;
  result_t               out_q;
  logic                  wr_en;
  logic [IW-1:0]         wr_addr;
  logic [DATA_W-1:0]     wr_data;
  logic                  rd_en;
  logic [IW-1:0]         rd_addr;
  logic [DATA_W-1:0]     rd_data;

  cfs_ctrl #(
    .DEPTH(DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_action (action_t'(s_tuser)),
    .in_value  (s_tdata),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data)
  );

  cfs_ram #(
    .WIDTH(DATA_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign m_tdata = {3'b000, out_q.position, out_q.data};
  assign m_tuser = out_q.status;
  assign m_tlast = out_q.last;

endmodule
`default_nettype wire

@@ src/cfs_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
module cfs_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                      clk,
  input  wire logic                      wr_en,
  input  wire logic [$clog2(DEPTH)-1:0]  wr_addr,
  input  wire logic [WIDTH-1:0]          wr_data,
  input  wire logic                      rd_en,
  input  wire logic [$clog2(DEPTH)-1:0]  rd_addr,
  output logic      [WIDTH-1:0]          rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

@@ src/cfs_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
module cfs_ctrl #(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire cfs_pkg::action_t                  in_action,
  input  wire logic signed [cfs_pkg::DATA_W-1:0] in_value,
  output logic                                   res_valid,
  input  wire logic                              res_ready,
  output cfs_pkg::result_t                       res,
  output logic                                   wr_en,
  output logic [$clog2(DEPTH)-1:0]               wr_addr,
  output logic [cfs_pkg::DATA_W-1:0]             wr_data,
  output logic                                   rd_en,
  output logic [$clog2(DEPTH)-1:0]               rd_addr,
  input  wire logic [cfs_pkg::DATA_W-1:0]        rd_data
);
  import cfs_pkg::*;

  localparam int unsigned IW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_RESP   = 4'b0010,
    S_WALK   = 4'b0100,
    S_FINISH = 4'b1000
  } state_t;

  function automatic logic [IW-1:0] wrap_next(input logic [IW-1:0] i);
    logic [IW-1:0] r;
    if (i == IW'(DEPTH - 1)) begin
      r = '0;
    end else begin
      r = i + 1'b1;
    end
    return r;
  endfunction

  state_t                   state, state_next;
  logic [IW-1:0]            head, head_next;
  logic [IW-1:0]            tail, tail_next;
  logic                     empty, empty_next;
  logic [CW-1:0]            count, count_next;
  action_t                  act_q, act_q_next;
  logic [DATA_W-1:0]        key_q, key_q_next;
  status_t                  st_q, st_q_next;
  logic                     deq_q, deq_q_next;
  logic [IW-1:0]            rd_idx, rd_idx_next;
  logic [CW-1:0]            left, left_next;
  logic                     dvalid, dvalid_next;
  logic [POS_W-1:0]         pos, pos_next;
  logic                     pend_valid, pend_valid_next;
  logic [DATA_W-1:0]        pend_data, pend_data_next;
  logic [POS_W-1:0]         pend_pos, pend_pos_next;
  logic                     is_disp;
  logic                     match;
  logic                     emit_need;

  assign in_ready  = (state == S_IDLE);
  assign is_disp   = (act_q == ACT_DISPLAY);
  assign match     = (rd_data == key_q);
  assign emit_need = dvalid && (is_disp || (match && pend_valid));

  always_comb begin
    state_next      = state;
    head_next       = head;
    tail_next       = tail;
    empty_next      = empty;
    count_next      = count;
    act_q_next      = act_q;
    key_q_next      = key_q;
    st_q_next       = st_q;
    deq_q_next      = deq_q;
    rd_idx_next     = rd_idx;
    left_next       = left;
    dvalid_next     = dvalid;
    pos_next        = pos;
    pend_valid_next = pend_valid;
    pend_data_next  = pend_data;
    pend_pos_next   = pend_pos;
    wr_en           = 1'b0;
    wr_addr         = empty ? '0 : wrap_next(tail);
    wr_data         = in_value;
    rd_en           = 1'b0;
    rd_addr         = rd_idx;
    res_valid       = 1'b0;
    res             = '{status: ST_OK, data: '0, position: '0, last: 1'b0};

    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          act_q_next = in_action;
          key_q_next = in_value;
          deq_q_next = 1'b0;
          st_q_next  = ST_OK;
          state_next = S_RESP;
          if (in_action == ACT_ENQUEUE) begin
            if (empty) begin
              wr_en      = 1'b1;
              head_next  = '0;
              tail_next  = '0;
              empty_next = 1'b0;
              count_next = CW'(1);
            end else if (count == CW'(DEPTH)) begin
              st_q_next = ST_FULL;
            end else begin
              wr_en      = 1'b1;
              tail_next  = wrap_next(tail);
              count_next = count + 1'b1;
            end
          end else if (empty) begin
            st_q_next = ST_EMPTY;
          end else if (in_action == ACT_DEQUEUE) begin
            rd_en      = 1'b1;
            rd_addr    = head;
            deq_q_next = 1'b1;
            if (count == CW'(1)) begin
              empty_next = 1'b1;
              head_next  = '0;
              tail_next  = '0;
              count_next = '0;
            end else begin
              head_next  = wrap_next(head);
              count_next = count - 1'b1;
            end
          end else begin
            rd_idx_next     = head;
            left_next       = count;
            dvalid_next     = 1'b0;
            pos_next        = '0;
            pend_valid_next = 1'b0;
            state_next      = S_WALK;
          end
        end
      end
      S_RESP: begin
        res_valid = 1'b1;
        res = '{status: st_q, data: deq_q ? rd_data : '0, position: '0, last: 1'b1};
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end
      S_WALK: begin
        if (dvalid && is_disp) begin
          res_valid = 1'b1;
          res = '{status: ST_OK, data: rd_data, position: pos, last: (left == '0)};
        end else if (dvalid && match && pend_valid) begin
          res_valid = 1'b1;
          res = '{status: ST_FOUND, data: pend_data, position: pend_pos, last: 1'b0};
        end
        if (!emit_need || res_ready) begin
          if (dvalid && !is_disp && match) begin
            pend_valid_next = 1'b1;
            pend_data_next  = rd_data;
            pend_pos_next   = pos;
          end
          if (left != '0) begin
            rd_en       = 1'b1;
            rd_idx_next = wrap_next(rd_idx);
            left_next   = left - 1'b1;
            dvalid_next = 1'b1;
            pos_next    = pos + 1'b1;
          end else begin
            dvalid_next = 1'b0;
            if (dvalid) begin
              state_next = is_disp ? S_IDLE : S_FINISH;
            end
          end
        end
      end
      S_FINISH: begin
        res_valid = 1'b1;
        if (pend_valid) begin
          res = '{status: ST_FOUND, data: pend_data, position: pend_pos, last: 1'b1};
        end else begin
          res = '{status: ST_NOTFOUND, data: '0, position: '0, last: 1'b1};
        end
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      head       <= '0;
      tail       <= '0;
      empty      <= 1'b1;
      count      <= '0;
      dvalid     <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      state      <= state_next;
      head       <= head_next;
      tail       <= tail_next;
      empty      <= empty_next;
      count      <= count_next;
      dvalid     <= dvalid_next;
      pend_valid <= pend_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    act_q     <= act_q_next;
    key_q     <= key_q_next;
    st_q      <= st_q_next;
    deq_q     <= deq_q_next;
    rd_idx    <= rd_idx_next;
    left      <= left_next;
    pos       <= pos_next;
    pend_data <= pend_data_next;
    pend_pos  <= pend_pos_next;
  end

endmodule
`default_nettype wire

@@ bench/circular_fifo_with_search_unit_tb.sv @@
`timescale 1ns / 1ps
module circular_fifo_with_search_unit_tb;
  import cfs_pkg::*;

  localparam int FIFO_DEPTH = 16;
  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_ITEMS = 74;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  typedef struct {
    action_t     act;
    logic [31:0] val;
    bit          typed;
    status_t     st;
  } stim_row_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [31:0] s_tdata;
  logic [1:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [39:0] m_tdata;
  logic [2:0]  m_tuser;
  logic        m_tlast;

  logic [31:0] q_words [FIFO_DEPTH];
  int          q_front;
  int          q_back;
  bit          q_empty;

  result_t     expected_results [$];
  stim_row_t   directed_rows [$];
  idle_mode_t  idle_mode;
  int          mismatch_count;

  circular_fifo_with_search_unit #(.DEPTH(FIFO_DEPTH)) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Mismatches found");
    $finish;
  end

  function automatic int held_words();
    if (q_empty) return 0;
    return ((q_back + FIFO_DEPTH - q_front) % FIFO_DEPTH) + 1;
  endfunction

  function automatic void apply_command(input action_t act, input logic [31:0] val,
                                        ref result_t res [$]);
    int count;
    int idx;
    int i;
    result_t r;
    res.delete();
    r.status = ST_OK;
    r.data = '0;
    r.position = '0;
    r.last = 1'b1;
    if (act == ACT_ENQUEUE) begin
      if (q_empty) begin
        q_front = 0;
        q_back = 0;
        q_words[0] = val;
        q_empty = 1'b0;
      end else if ((q_back + 1) % FIFO_DEPTH == q_front) begin
        r.status = ST_FULL;
      end else begin
        q_back = (q_back + 1) % FIFO_DEPTH;
        q_words[q_back] = val;
      end
      res.push_back(r);
      return;
    end
    if (q_empty) begin
      r.status = ST_EMPTY;
      res.push_back(r);
      return;
    end
    if (act == ACT_DEQUEUE) begin
      r.data = q_words[q_front];
      res.push_back(r);
      if (q_front == q_back) begin
        q_empty = 1'b1;
        q_front = 0;
        q_back = 0;
      end else begin
        q_front = (q_front + 1) % FIFO_DEPTH;
      end
      return;
    end
    count = held_words();
    idx = q_front;
    for (i = 1; i <= count; i++) begin
      if (act == ACT_DISPLAY) begin
        r.status = ST_OK;
        r.data = q_words[idx];
        r.position = i[4:0];
        r.last = (i == count);
        res.push_back(r);
      end else if (q_words[idx] == val) begin
        r.status = ST_FOUND;
        r.data = q_words[idx];
        r.position = i[4:0];
        r.last = 1'b0;
        res.push_back(r);
      end
      idx = (idx + 1) % FIFO_DEPTH;
    end
    if (act == ACT_SEARCH) begin
      if (res.size() == 0) begin
        r.status = ST_NOTFOUND;
        r.data = '0;
        r.position = '0;
        r.last = 1'b1;
        res.push_back(r);
      end else begin
        res[res.size() - 1].last = 1'b1;
      end
    end
  endfunction

  function automatic bit roll(input idle_mode_t only, input int pct);
    if (idle_mode == only) return $urandom_range(99) < pct;
    if (idle_mode == IDLE_BOTH) return $urandom_range(99) < 14;
    return 1'b0;
  endfunction

  function automatic logic [31:0] pick_word();
    case ($urandom_range(7))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'hFFFF_FFFF;
      3: return 32'h0000_0000;
      4, 5: return $urandom_range(3);
      default: return $urandom;
    endcase
  endfunction

  function automatic void add_row(input action_t act, input logic [31:0] val,
                                  input bit typed, input status_t st);
    stim_row_t row;
    row.act = act;
    row.val = val;
    row.typed = typed;
    row.st = st;
    directed_rows.push_back(row);
  endfunction

  task automatic send_word(input action_t act, input logic [31:0] val,
                           input bit typed, input status_t st);
    result_t predicted [$];
    result_t fixed;
    while (roll(IDLE_SEND, 67)) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= val;
    s_tuser <= act;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    apply_command(act, val, predicted);
    if (typed) begin
      fixed.status = st;
      fixed.data = '0;
      fixed.position = '0;
      fixed.last = 1'b1;
      expected_results.push_back(fixed);
    end else begin
      foreach (predicted[k]) expected_results.push_back(predicted[k]);
    end
  endtask

  always @(posedge clk) begin : receive_side
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected word: status=%0d data=%h pos=%0d last=%0b", m_tuser,
                   m_tdata[31:0], m_tdata[36:32], m_tlast);
      end else begin
        want = expected_results.pop_front();
        if (m_tuser != want.status || m_tdata[31:0] != want.data ||
            m_tdata[36:32] != want.position || m_tlast != want.last ||
            m_tdata[39:37] != 3'b000) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: exp %0d %h %0d %0b, got %0d %h %0d %0b pad=%b",
                     want.status, want.data, want.position, want.last, m_tuser,
                     m_tdata[31:0], m_tdata[36:32], m_tlast, m_tdata[39:37]);
        end
      end
    end
    m_tready <= !roll(IDLE_RECV, 67);
  end

  initial begin : stimulus
    int sent;
    int burst_len;
    int enq_bias;
    int pick;
    int held;
    action_t act;
    logic [31:0] val;
    rst <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata <= '0;
    s_tuser <= ACT_ENQUEUE;
    m_tready <= 1'b0;
    idle_mode = IDLE_NONE;
    mismatch_count = 0;
    q_front = 0;
    q_back = 0;
    q_empty = 1'b1;

    add_row(ACT_DEQUEUE, 32'h0, 1'b1, ST_EMPTY);
    add_row(ACT_DISPLAY, 32'h0, 1'b1, ST_EMPTY);
    add_row(ACT_SEARCH, 32'h0, 1'b1, ST_EMPTY);
    add_row(ACT_ENQUEUE, 32'h8000_0000, 1'b1, ST_OK);
    add_row(ACT_ENQUEUE, 32'h7FFF_FFFF, 1'b1, ST_OK);
    add_row(ACT_SEARCH, 32'h1234_5678, 1'b1, ST_NOTFOUND);
    add_row(ACT_DEQUEUE, 32'h0, 1'b0, ST_OK);
    for (int k = 0; k < FIFO_DEPTH - 1; k++)
      add_row(ACT_ENQUEUE, (k % 3 == 0) ? 32'hFFFF_FFFF : k, 1'b1, ST_OK);
    add_row(ACT_ENQUEUE, 32'h1, 1'b1, ST_FULL);
    add_row(ACT_SEARCH, 32'hFFFF_FFFF, 1'b0, ST_OK);
    add_row(ACT_DISPLAY, 32'h0, 1'b0, ST_OK);

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[r])
      send_word(directed_rows[r].act, directed_rows[r].val, directed_rows[r].typed,
                directed_rows[r].st);

    for (int ph = 0; ph < 4; ph++) begin
      idle_mode = idle_mode_t'(ph);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        burst_len = $urandom_range(6, 24);
        case ($urandom_range(2))
          0: enq_bias = 80;
          1: enq_bias = 50;
          default: enq_bias = 15;
        endcase
        for (int k = 0; k < burst_len && sent < PHASE_ITEMS; k++) begin
          pick = $urandom_range(99);
          val = pick_word();
          if (pick < enq_bias) act = ACT_ENQUEUE;
          else if (pick < enq_bias + (100 - enq_bias) / 2) act = ACT_DEQUEUE;
          else if ($urandom_range(4) < 2) act = ACT_DISPLAY;
          else act = ACT_SEARCH;
          held = held_words();
          if (act == ACT_SEARCH && held > 0 && $urandom_range(1))
            val = q_words[(q_front + $urandom_range(held - 1)) % FIFO_DEPTH];
          send_word(act, val, 1'b0, ST_OK);
          sent++;
        end
      end
    end
    s_tvalid <= 1'b0;

    while (expected_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

@@ files.f @@
src/cfs_pkg.sv
src/cfs_ram.sv
src/cfs_ctrl.sv
src/circular_fifo_with_search_unit.sv
bench/circular_fifo_with_search_unit_tb.sv
